// File: rtl/amb_pkg.sv
// Shared types, widths and codes of the adaptive mean binarizer.
package amb_pkg;

    localparam int PIX_W = 8;
    localparam int COL_W = 11;
    localparam int ROW_W = 13;
    localparam int WIN_W = 4;
    localparam int OFS_W = 9;
    localparam int SUM_W = 16;
    localparam int CNT_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam int DEF_MAX_WIDTH = 1024;
    localparam int DEF_MAX_WINDOW = 15;

    localparam logic [COL_W-1:0] RST_WIDTH = 11'd1024;
    localparam logic [ROW_W-1:0] RST_HEIGHT = 13'd480;
    localparam logic [WIN_W-1:0] RST_WINDOW = 4'd3;
    localparam logic [OFS_W-1:0] RST_OFFSET = 9'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_WINDOW = 2'd2,
        CFG_OFFSET = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CENTER,
        B_SCAN,
        B_TAIL,
        B_MUL,
        B_PUSH
    } t_bstate;

    typedef struct packed {
        logic [COL_W-1:0] w;
        logic [ROW_W-1:0] h;
        logic [WIN_W-1:0] back;
        logic [WIN_W-1:0] ahead;
    } t_geom;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] r0;
        logic [ROW_W-1:0] r1;
        logic [COL_W-1:0] c0;
        logic [COL_W-1:0] c1;
        logic             last;
    } t_job;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] data;
    } t_wr;

endpackage

// File: rtl/amb_front.sv
// Front part: takes input beats, writes pixels, decides when a window is complete.
module amb_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_restart,
    input  amb_pkg::t_geom      i_geom,
    input  logic                i_push,
    input  logic                i_op,
    input  logic [amb_pkg::PIX_W-1:0] i_pixel,
    input  logic                i_pop_job,
    input  logic                i_back_busy,
    output logic                o_full,
    output amb_pkg::t_wr        o_wr,
    output logic                o_job_valid,
    output amb_pkg::t_job       o_job
);
    import amb_pkg::*;

    logic [COL_W-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [ROW_W-1:0] r_in_row, n_in_row, r_out_row, n_out_row;
    logic             r_q_valid, r_wait;
    t_job             r_q_job, job;
    logic             accept, take, ready, emit;
    logic [ROW_W:0]   row_sum;
    logic [COL_W:0]   col_sum;
    logic [ROW_W-1:0] hm1, need_r;
    logic [COL_W-1:0] wm1, need_c;

    assign o_full = r_q_valid | r_wait;
    assign accept = i_push & ~o_full;
    assign take = accept && (i_op == OP_PIXEL) && (r_in_row < i_geom.h);
    assign hm1 = i_geom.h - 1'b1;
    assign wm1 = i_geom.w - 1'b1;

    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (take) begin
            if ((COL_W+1)'(r_in_col) + (COL_W+1)'(1) >= (COL_W+1)'(i_geom.w)) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end
        row_sum = (ROW_W+1)'(r_out_row) + (ROW_W+1)'(i_geom.ahead);
        col_sum = (COL_W+1)'(r_out_col) + (COL_W+1)'(i_geom.ahead);
        need_r = (row_sum < (ROW_W+1)'(hm1)) ? row_sum[ROW_W-1:0] : hm1;
        need_c = (col_sum < (COL_W+1)'(wm1)) ? col_sum[COL_W-1:0] : wm1;
        ready = (n_in_row > need_r) || ((n_in_row == need_r) && (n_in_col > need_c));
        emit = accept && ready;
        job.row = r_out_row;
        job.col = r_out_col;
        job.r0 = (r_out_row >= ROW_W'(i_geom.back)) ? r_out_row - ROW_W'(i_geom.back) : '0;
        job.c0 = (r_out_col >= COL_W'(i_geom.back)) ? r_out_col - COL_W'(i_geom.back) : '0;
        job.r1 = need_r;
        job.c1 = need_c;
        job.last = (r_out_row == hm1) && (r_out_col == wm1);
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if (job.last) begin
                n_in_col = '0;
                n_in_row = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (r_out_col == wm1) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_q_valid <= 1'b0;
            r_wait <= 1'b0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            if (emit) begin
                r_q_valid <= 1'b1;
            end else if (i_pop_job) begin
                r_q_valid <= 1'b0;
            end
            if (emit && job.last) begin
                r_wait <= 1'b1;
            end else if (!r_q_valid && !i_back_busy) begin
                r_wait <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_q_job <= job;
        end
    end

    assign o_wr.we = take;
    assign o_wr.row = r_in_row;
    assign o_wr.col = r_in_col;
    assign o_wr.data = i_pixel;
    assign o_job_valid = r_q_valid;
    assign o_job = r_q_job;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !r_q_valid) else $error("job issued into an occupied queue");
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid && !i_pop_job && !i_restart |=> r_q_valid)
        else $error("queued job lost without being taken");
    a_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= i_geom.h) else $error("input row beyond frame");

endmodule

// File: rtl/amb_back.sv
// Back part: line store, window sum by scanning, threshold test and result queue.
module amb_back #(
    parameter int MAX_WIDTH  = amb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = amb_pkg::DEF_MAX_WINDOW
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  amb_pkg::t_wr             i_wr,
    input  logic                     i_job_valid,
    input  amb_pkg::t_job            i_job,
    input  logic [amb_pkg::OFS_W-1:0] i_offset,
    input  logic                     i_pop,
    output logic                     o_pop_job,
    output logic                     o_busy,
    output logic                     o_empty,
    output logic [amb_pkg::PIX_W-1:0] o_binary_pixel,
    output logic                     o_last_of_frame
);
    import amb_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int RING_W = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = RING_W + CB;
    localparam int DEPTH = 2 ** ADDR_W;

    logic [PIX_W-1:0]  mem [0:DEPTH-1];
    logic [PIX_W-1:0]  r_rdata, r_v;
    logic [ADDR_W-1:0] wa, ra;
    t_bstate           r_state, n_state;
    t_job              r_job;
    logic [ROW_W-1:0]  r_r;
    logic [COL_W-1:0]  r_c;
    logic              r_rd_ctr, r_rd_win, n_rd_ctr, n_rd_win;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic signed [18:0] r_prod;
    logic signed [9:0] vc;
    logic              scan_end, f_push, f_pop;
    logic [1:0]        r_f_data [0:1];
    logic              r_f_wp, r_f_rp;
    logic [1:0]        r_f_cnt;

    assign wa = {i_wr.row[RING_W-1:0], CB'(i_wr.col)};
    assign scan_end = (r_r == r_job.r1) && (r_c == r_job.c1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:   if (i_job_valid) n_state = B_CENTER;
            B_CENTER: n_state = B_SCAN;
            B_SCAN:   if (scan_end) n_state = B_TAIL;
            B_TAIL:   n_state = B_MUL;
            B_MUL:    n_state = B_PUSH;
            B_PUSH:   if (r_f_cnt != 2'd2) n_state = B_IDLE;
            default:  n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop_job = (r_state == B_IDLE) && i_job_valid;
        n_rd_ctr = (r_state == B_CENTER);
        n_rd_win = (r_state == B_SCAN);
        f_push = (r_state == B_PUSH) && (r_f_cnt != 2'd2);
        if (r_state == B_CENTER) begin
            ra = {r_job.row[RING_W-1:0], CB'(r_job.col)};
        end else begin
            ra = {r_r[RING_W-1:0], CB'(r_c)};
        end
    end

    assign o_busy = (r_state != B_IDLE);
    assign vc = $signed({2'b00, r_v}) + $signed({i_offset[OFS_W-1], i_offset});

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[wa] <= i_wr.data;
        end
        r_rdata <= mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_rd_ctr <= 1'b0;
            r_rd_win <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_ctr <= n_rd_ctr;
            r_rd_win <= n_rd_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_job) begin
            r_job <= i_job;
            r_r <= i_job.r0;
            r_c <= i_job.c0;
            r_sum <= '0;
            r_cnt <= '0;
        end else begin
            if (r_state == B_SCAN) begin
                if (r_c == r_job.c1) begin
                    r_c <= r_job.c0;
                    r_r <= r_r + 1'b1;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            if (r_rd_win) begin
                r_sum <= r_sum + SUM_W'(r_rdata);
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (r_rd_ctr) begin
            r_v <= r_rdata;
        end
        if (r_state == B_MUL) begin
            r_prod <= 19'(vc * $signed({1'b0, r_cnt}));
        end
    end

    assign f_pop = i_pop && (r_f_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_wp <= 1'b0;
            r_f_rp <= 1'b0;
            r_f_cnt <= 2'd0;
        end else begin
            if (f_push) r_f_wp <= ~r_f_wp;
            if (f_pop) r_f_rp <= ~r_f_rp;
            r_f_cnt <= r_f_cnt + 2'(f_push) - 2'(f_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_push) begin
            r_f_data[r_f_wp] <= {(r_prod > $signed({3'b000, r_sum})), r_job.last};
        end
    end

    assign o_empty = (r_f_cnt == 2'd0);
    assign o_binary_pixel = {PIX_W{r_f_data[r_f_rp][1]}};
    assign o_last_of_frame = r_f_data[r_f_rp][0];

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop_job |=> r_state == B_CENTER) else $error("job taken without scan start");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_MUL |-> r_cnt != '0) else $error("empty window summed");
    a_fifo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_cnt <= 2'd2) else $error("result queue overflow");

endmodule

// File: rtl/adaptive_mean_binarizer.sv
// Top level of the adaptive mean binarizer: configuration registers and the two parts.
// Usage: grayscale pixels enter in raster order through a queue-like port (i_push, o_full;
// a beat moves when i_push is high and o_full low). Each beat carries an op: a pixel, or a
// drain that moves the frame tail out without a new pixel. Binary results (0 or 255) leave
// through a queue-like port (o_empty, i_pop) with o_last_of_frame on the last pixel.
// The configuration port writes frame width, height, window size and offset; any write
// restarts the frame. Write it only while the block is idle.
// A result appears once the look-ahead half of its window has arrived; the back part
// reads the line store one pixel per cycle over the in-frame window pixels (up to 225).
// The front holds one job; it stalls input while that job waits, and at a frame end until
// the last result of the frame is computed. The back part works on one result at a time.
// Reset: positions return to zero and registers take width 1024, height 480, window 3,
// offset 0. A stalled receiver fills the two-entry result queue, then stalls the back
// part and through it the input; nothing is lost.
module adaptive_mean_binarizer #(
    parameter int MAX_WIDTH  = amb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = amb_pkg::DEF_MAX_WINDOW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [amb_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [amb_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_op,
    input  logic [amb_pkg::PIX_W-1:0]      i_pixel,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [amb_pkg::PIX_W-1:0]      o_binary_pixel,
    output logic                          o_last_of_frame
);
    import amb_pkg::*;

    logic [COL_W-1:0] r_cfg_width;
    logic [ROW_W-1:0] r_cfg_height;
    logic [WIN_W-1:0] r_cfg_window;
    logic [OFS_W-1:0] r_cfg_offset;
    logic [WIN_W-1:0] win;
    t_geom            geom;
    t_wr              wr;
    t_job             job;
    logic             job_valid, pop_job, back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= RST_WIDTH;
            r_cfg_height <= RST_HEIGHT;
            r_cfg_window <= RST_WINDOW;
            r_cfg_offset <= RST_OFFSET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_WIDTH:  r_cfg_width <= i_cfg_wdata[COL_W-1:0];
                CFG_HEIGHT: r_cfg_height <= i_cfg_wdata[ROW_W-1:0];
                CFG_WINDOW: r_cfg_window <= i_cfg_wdata[WIN_W-1:0];
                CFG_OFFSET: r_cfg_offset <= i_cfg_wdata[OFS_W-1:0];
                default:    r_cfg_offset <= r_cfg_offset;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_width == '0) begin
            geom.w = COL_W'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            geom.w = COL_W'(MAX_WIDTH);
        end else begin
            geom.w = r_cfg_width;
        end
        geom.h = (r_cfg_height == '0) ? ROW_W'(1) : r_cfg_height;
        if (r_cfg_window == '0) begin
            win = WIN_W'(1);
        end else if (int'(r_cfg_window) > MAX_WINDOW) begin
            win = WIN_W'(MAX_WINDOW);
        end else begin
            win = r_cfg_window;
        end
        geom.back = win >> 1;
        geom.ahead = win - 1'b1 - (win >> 1);
    end

    amb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (i_cfg_we),
        .i_geom      (geom),
        .i_push      (i_push),
        .i_op        (i_op),
        .i_pixel     (i_pixel),
        .i_pop_job   (pop_job),
        .i_back_busy (back_busy),
        .o_full      (o_full),
        .o_wr        (wr),
        .o_job_valid (job_valid),
        .o_job       (job)
    );

    amb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .i_offset        (r_cfg_offset),
        .i_pop           (i_pop),
        .o_pop_job       (pop_job),
        .o_busy          (back_busy),
        .o_empty         (o_empty),
        .o_binary_pixel  (o_binary_pixel),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

// File: test/testbench.sv
// Self-checking testbench for the adaptive mean binarizer, with its own window-mean predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import amb_pkg::*;

    localparam int STORE_ROWS = DEF_MAX_WINDOW + 1;
    localparam int SETTLE = 300;

    typedef struct {
        bit       is_cfg;
        t_cfg_idx idx;
        logic [CFG_DATA_W-1:0] data;
        t_op      op;
        logic [PIX_W-1:0] pix;
        bit       typed;
        logic [PIX_W-1:0] exp_bin;
        logic     exp_last;
    } t_row;

    typedef struct {
        logic [PIX_W-1:0] bin;
        logic             last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic i_push = 1'b0;
    logic i_op = 1'b0;
    logic [PIX_W-1:0] i_pixel = '0;
    logic i_pop = 1'b0;
    logic o_full, o_empty, o_last_of_frame;
    logic [PIX_W-1:0] o_binary_pixel;

    adaptive_mean_binarizer dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state.
    logic [PIX_W-1:0] pix_store [STORE_ROWS*DEF_MAX_WIDTH];
    int unsigned cfg_w = RST_WIDTH, cfg_h = RST_HEIGHT, cfg_s = RST_WINDOW;
    int ofs = 0;
    int unsigned in_col, in_row, out_col, out_row;
    bit frame_done;

    t_res expected_q[$];
    int errors = 0, results = 0, pixels_sent = 0, frames_done = 0, cfg_writes = 0;
    bit long_gaps = 1'b1;
    bit stall_req = 1'b0, stall_done = 1'b0;

    function automatic int unsigned slot(int unsigned r, int unsigned c);
        return (r % STORE_ROWS) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH);
    endfunction

    function automatic bit binarize_step(t_op op, logic [PIX_W-1:0] pix,
                                         output t_res res);
        int unsigned w, h, s, back, ahead, need_r, need_c, r0, c0, cnt, sum;
        int v;
        w = (cfg_w == 0) ? 1 : (cfg_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : cfg_w);
        h = (cfg_h == 0) ? 1 : cfg_h;
        s = (cfg_s == 0) ? 1 : (cfg_s > DEF_MAX_WINDOW ? DEF_MAX_WINDOW : cfg_s);
        back = s / 2;
        ahead = s - 1 - s / 2;
        cnt = 0;
        sum = 0;
        if (op == OP_PIXEL && in_row < h) begin
            pix_store[slot(in_row, in_col)] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        need_r = (out_row + ahead < h - 1) ? out_row + ahead : h - 1;
        need_c = (out_col + ahead < w - 1) ? out_col + ahead : w - 1;
        if (!(in_row > need_r || (in_row == need_r && in_col > need_c)))
            return 1'b0;
        r0 = (out_row >= back) ? out_row - back : 0;
        c0 = (out_col >= back) ? out_col - back : 0;
        for (int unsigned r = r0; r <= need_r; r++)
            for (int unsigned c = c0; c <= need_c; c++) begin
                sum += pix_store[slot(r, c)];
                cnt++;
            end
        v = int'(pix_store[slot(out_row, out_col)]);
        res.last = (out_row == h - 1) && (out_col == w - 1);
        res.bin = ((v + ofs) * int'(cnt) > int'(sum)) ? 8'd255 : 8'd0;
        if (res.last) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            frame_done = 1'b1;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    task automatic wait_idle();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_WIDTH:  cfg_w = data[COL_W-1:0];
            CFG_HEIGHT: cfg_h = data[ROW_W-1:0];
            CFG_WINDOW: cfg_s = data[WIN_W-1:0];
            CFG_OFFSET: ofs = int'(signed'(data[OFS_W-1:0]));
            default: ;
        endcase
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        cfg_writes++;
    endtask

    // Sends one beat; a typed expectation, when given, replaces the predicted one.
    task automatic send_beat(t_op op, logic [PIX_W-1:0] pix, bit typed = 1'b0,
                             logic [PIX_W-1:0] exp_bin = '0, logic exp_last = 1'b0);
        t_res res;
        int gap;
        gap = 0;
        if ($urandom_range(0, 3) == 0)
            gap = (long_gaps && $urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                            : $urandom_range(1, 3);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_op <= op;
        i_pixel <= pix;
        do @(posedge i_clk); while (o_full);
        if (binarize_step(op, pix, res)) begin
            if (typed) begin
                res.bin = exp_bin;
                res.last = exp_last;
            end
            expected_q.insert(expected_q.size(), res);
        end else if (typed) begin
            $display("%0t: directed beat expected a result, predictor gives none", $time);
            errors++;
        end
        if (op == OP_PIXEL) pixels_sent++;
    endtask

    // Directed stimulus: clamped registers, offset extremes, drains, an even window.
    t_row dir_rows[] = '{
        '{1, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{1, CFG_HEIGHT, 13'd0,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{1, CFG_WINDOW, 13'd0,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd0,   1, 8'd0,   1},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd255, 1, 8'd0,   1},
        '{1, CFG_OFFSET, 13'd1,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd255, 1, 8'd255, 1},
        '{1, CFG_OFFSET, 13'h101,  OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd255, 1, 8'd0,   1},
        '{1, CFG_OFFSET, 13'h0ff,  OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd0,   1, 8'd255, 1},
        '{1, CFG_WIDTH,  13'd3,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{1, CFG_HEIGHT, 13'd2,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{1, CFG_WINDOW, 13'd4,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{1, CFG_OFFSET, 13'd0,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_DRAIN, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd10,  0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd200, 0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd255, 0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd90,  0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd91,  0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd33,  0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd44,  0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_DRAIN, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_DRAIN, 8'd0,   0, 8'd0,   0},
        '{1, CFG_WIDTH,  13'd2047, OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{1, CFG_HEIGHT, 13'd8191, OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{1, CFG_WINDOW, 13'd15,   OP_PIXEL, 8'd0,   0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd128, 0, 8'd0,   0},
        '{0, CFG_WIDTH,  13'd0,    OP_PIXEL, 8'd127, 0, 8'd0,   0}
    };

    initial begin
        int unsigned w, h, npix;
        int sel;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                i_push <= 1'b0;
                wait_idle();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_beat(dir_rows[k].op, dir_rows[k].pix, dir_rows[k].typed,
                          dir_rows[k].exp_bin, dir_rows[k].exp_last);
            end
        end
        while (pixels_sent < 1600) begin
            i_push <= 1'b0;
            wait_idle();
            sel = $urandom_range(0, 29);
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 12);
            case (sel)
                0: begin w = 1024; h = 1; end
                1: begin w = 1; h = $urandom_range(100, 300); end
                2: w = ($urandom_range(0, 1) == 0) ? 0 : 2047;
                3: h = 0;
                4: h = 8191;
                default: ;
            endcase
            if (!stall_done) begin
                w = 16;
                h = 12;
            end
            long_gaps = ($urandom_range(0, 2) != 0);
            write_reg(CFG_WIDTH, 13'(w));
            write_reg(CFG_HEIGHT, 13'(h));
            write_reg(CFG_WINDOW, 13'($urandom_range(0, 15)));
            write_reg(CFG_OFFSET, ($urandom_range(0, 9) == 0)
                ? (($urandom_range(0, 1) == 0) ? 13'h0ff : 13'h101)
                : 13'(9'(signed'($urandom_range(0, 40)) - 20)));
            w = (w == 0) ? 1 : (w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w);
            h = (h == 0) ? 1 : h;
            npix = w * h;
            if (npix > 1100 || $urandom_range(0, 9) == 0)
                npix = $urandom_range(1, (npix > 600) ? 600 : npix);
            if (!stall_done) begin
                // The receiver holds off for a long stretch during this frame.
                npix = w * h;
                stall_req = 1'b1;
                stall_done = 1'b1;
            end
            frame_done = 1'b0;
            for (int unsigned n = 0; n < npix; n++) begin
                if ($urandom_range(0, 19) == 0)
                    send_beat(OP_DRAIN, 8'($urandom_range(0, 255)));
                send_beat(OP_PIXEL, 8'($urandom_range(0, 255)));
            end
            if (npix == w * h) begin
                // A pixel after the frame input is complete acts as a drain.
                while (!frame_done)
                    send_beat(($urandom_range(0, 3) == 0) ? OP_PIXEL : OP_DRAIN,
                              8'($urandom_range(0, 255)));
                frames_done++;
            end
        end
        i_push <= 1'b0;
        wait_idle();
        if (expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            errors++;
        end
        $display("Covered %0d pixels, %0d results, %0d complete frames, %0d register writes.",
                 pixels_sent, results, frames_done, cfg_writes);
        if (errors == 0)
            $display("adaptive_mean_binarizer regression: pass");
        else
            $display("adaptive_mean_binarizer regression: fail");
        $finish;
    end

    // Receiver: random pop gaps, plus a long hold-off now and then so the block fills up.
    initial begin
        int hold;
        int unsigned cyc;
        t_res want;
        hold = 0;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (i_rst_n && i_pop && !o_empty) begin
                results++;
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected beat bin=%0d last=%0b", $time,
                             o_binary_pixel, o_last_of_frame);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_binary_pixel !== want.bin || o_last_of_frame !== want.last) begin
                        $display("%0t: mismatch expected bin=%0d last=%0b actual bin=%0d last=%0b",
                                 $time, want.bin, want.last, o_binary_pixel, o_last_of_frame);
                        errors++;
                    end
                end
            end
            if (stall_req) begin
                stall_req = 1'b0;
                hold = 2000;
            end
            if (cyc % 40000 == 20000) hold = $urandom_range(400, 800);
            if (hold > 0) begin
                hold--;
                i_pop <= 1'b0;
            end else if ((cyc / 3000) % 3 == 0) begin
                i_pop <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_pop <= 1'b0;
                hold = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 2);
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
        $display("adaptive_mean_binarizer regression: fail");
        $finish;
    end

endmodule
